// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define SOB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define SOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOB_ASSERT_IMPL(label, ante, cons, msg)
`define SOB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/sob_pkg.sv -----
// ----------------------------------------------------------------------------
// sob_pkg
// Shared constants and types of the skyline outline builder.
// ----------------------------------------------------------------------------
package sob_pkg;

  localparam int X_SPAN_DEF      = 1024;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam int LEFT_W      = 10;
  localparam int COORD_W     = 11;
  localparam int IN_HEIGHT_W = 16;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // classified command: right already saturated, empty adds never queued
  typedef struct packed {
    op_t                    op;
    logic [COORD_W-1:0]     left;
    logic [COORD_W-1:0]     right;
    logic [IN_HEIGHT_W-1:0] height;
  } item_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

endpackage

// ----- rtl/sob_front.sv -----
// ----------------------------------------------------------------------------
// sob_front
// Command intake: handshake, right edge saturation, empty add filtering.
// ----------------------------------------------------------------------------
module sob_front #(
  parameter int X_SPAN = sob_pkg::X_SPAN_DEF
) (
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [sob_pkg::LEFT_W-1:0]      in_left_edge,
  input  logic [sob_pkg::COORD_W-1:0]     in_right_edge,
  input  logic [sob_pkg::IN_HEIGHT_W-1:0] in_building_height,
  input  logic                           q_full,
  input  sob_pkg::back_stat_t            stat,
  output logic                           push,
  output sob_pkg::item_t                 item
);

  localparam int CW      = sob_pkg::COORD_W;
  localparam int CAP_INT = (X_SPAN < (1 << CW)) ? X_SPAN : (1 << CW) - 1;
  localparam logic [CW-1:0] RIGHT_CAP = CW'(CAP_INT);

  logic          accept;
  logic          empty_bld;
  logic [CW-1:0] right_sat;
  logic [CW-1:0] left_ext;

  assign busy   = q_full || stat.init_busy;
  assign accept = start && !busy;

  assign right_sat = (in_right_edge > RIGHT_CAP) ? RIGHT_CAP : in_right_edge;
  assign left_ext  = {1'b0, in_left_edge};
  assign empty_bld = (left_ext >= right_sat);

  assign item.op     = sob_pkg::op_t'(in_command);
  assign item.left   = left_ext;
  assign item.right  = right_sat;
  assign item.height = in_building_height;

  // an add that covers no column is dropped here
  assign push = accept && ((item.op == sob_pkg::OP_FETCH) || !empty_bld);

endmodule

// ----- rtl/sob_queue.sv -----
// ----------------------------------------------------------------------------
// sob_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module sob_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sob_pkg::item_t push_item,
  input  logic           pop,
  output sob_pkg::item_t head_item,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = sob_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  sob_pkg::item_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]  count_r, count_nxt;

  assign full      = (count_r == NW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/sob_back.sv -----
// ----------------------------------------------------------------------------
// sob_back
// Command execution: column store, add walk, fetch scan and clearing sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sob_back #(
  parameter int X_SPAN      = sob_pkg::X_SPAN_DEF,
  parameter int HEIGHT_BITS = sob_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sob_pkg::item_t                  item,
  input  logic                            q_empty,
  output sob_pkg::back_stat_t             stat,
  output logic                            out_valid,
  output logic [sob_pkg::COORD_W-1:0]     out_point_x,
  output logic [sob_pkg::IN_HEIGHT_W-1:0] out_point_height,
  output logic                            out_last_point
);

  localparam int AW  = (X_SPAN > 1) ? $clog2(X_SPAN) : 1;
  localparam int HW  = HEIGHT_BITS;
  localparam int CW  = sob_pkg::COORD_W;
  localparam int IHW = sob_pkg::IN_HEIGHT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADD   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic           init_r, init_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [AW-1:0]  clr_last_r, clr_last_nxt;
  logic [CW-1:0]  max_right_r, max_right_nxt;
  logic [CW-1:0]  scan_pos_r, scan_pos_nxt;
  logic [HW-1:0]  prev_h_r, prev_h_nxt;
  logic [CW-1:0]  a_r, a_nxt;
  logic [CW-1:0]  end_r, end_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  out_x_r, out_x_nxt;
  logic [IHW-1:0] out_h_r, out_h_nxt;
  logic           out_last_r, out_last_nxt;

  logic [HW-1:0]  mem [X_SPAN];
  logic [HW-1:0]  rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  wa;
  logic [HW-1:0]  wd;

  logic           pop;
  logic           fin;
  logic [CW-1:0]  a_inc;

  assign pop            = (state_r == S_IDLE) && !q_empty;
  assign stat.pop       = pop;
  assign stat.init_busy = init_r;
  assign a_inc          = a_r + 1'b1;

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_x_r;
  assign out_point_height = out_h_r;
  assign out_last_point   = out_last_r;

  // read one column ahead: the data for a_r is in rd_data_r while in ADD or SCAN
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (item.op == sob_pkg::OP_ADD) ? AW'(item.left) : AW'(scan_pos_r);
    end else begin
      rd_addr = AW'(a_inc);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = AW'(a_r);
    wd = h_r;
    case (state_r)
      S_ADD: begin
        we = (rd_data_r < h_r);
      end
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        wd = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    clr_nxt       = clr_r;
    clr_last_nxt  = clr_last_r;
    max_right_nxt = max_right_r;
    scan_pos_nxt  = scan_pos_r;
    prev_h_nxt    = prev_h_r;
    a_nxt         = a_r;
    end_nxt       = end_r;
    h_nxt         = h_r;
    out_valid_nxt = 1'b0;
    out_x_nxt     = out_x_r;
    out_h_nxt     = out_h_r;
    out_last_nxt  = out_last_r;
    fin           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (item.op == sob_pkg::OP_ADD) begin
            a_nxt     = item.left;
            end_nxt   = item.right;
            h_nxt     = HW'(item.height);
            state_nxt = S_ADD;
            if (item.right > max_right_r) begin
              max_right_nxt = item.right;
            end
          end else if (scan_pos_r < max_right_r) begin
            a_nxt     = scan_pos_r;
            state_nxt = S_SCAN;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_ADD: begin
        if (a_inc < end_r) begin
          a_nxt = a_inc;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_data_r != prev_h_r) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = a_r;
          out_h_nxt     = IHW'(rd_data_r);
          out_last_nxt  = 1'b0;
          prev_h_nxt    = rd_data_r;
          scan_pos_nxt  = a_inc;
          state_nxt     = S_IDLE;
        end else if (a_inc < max_right_r) begin
          a_nxt = a_inc;
        end else begin
          fin = 1'b1;
        end
      end
      S_CLEAR: begin
        if (clr_r == clr_last_r) begin
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // final point: report (max right, 0), then wipe the columns that were used
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = max_right_r;
      out_h_nxt     = '0;
      out_last_nxt  = 1'b1;
      max_right_nxt = '0;
      scan_pos_nxt  = '0;
      prev_h_nxt    = '0;
      if (max_right_r != '0) begin
        clr_nxt      = '0;
        clr_last_nxt = AW'(max_right_r - 1'b1);
        state_nxt    = S_CLEAR;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      clr_last_r  <= AW'(X_SPAN - 1);
      max_right_r <= '0;
      scan_pos_r  <= '0;
      prev_h_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      clr_last_r  <= clr_last_nxt;
      max_right_r <= max_right_nxt;
      scan_pos_r  <= scan_pos_nxt;
      prev_h_r    <= prev_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    end_r      <= end_nxt;
    h_r        <= h_nxt;
    out_x_r    <= out_x_nxt;
    out_h_r    <= out_h_nxt;
    out_last_r <= out_last_nxt;
  end

  `SOB_ASSERT_IMPL(a_add_in_range, state_r == S_ADD, a_r < end_r, "add walk past right edge")
  `SOB_ASSERT_IMPL(a_scan_in_range, state_r == S_SCAN, a_r < max_right_r, "scan past max right")
  `SOB_ASSERT_IMPL(a_init_clear, init_r, state_r == S_CLEAR, "init flag outside clear sweep")
  `SOB_ASSERT_IMPL(a_last_wipes, out_valid_r && out_last_r, (max_right_r == '0) && (scan_pos_r == '0), "state kept after final point")
  `SOB_ASSERT_NEXT(a_init_done, init_r && (clr_r == clr_last_r), !init_r && (state_r == S_IDLE), "init sweep did not end")

endmodule

// ----- rtl/skyline_outline_builder_unit.sv -----
// ----------------------------------------------------------------------------
// skyline_outline_builder_unit
// Builds a building outline in a column height store and reads it back.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: start/busy. A command transfers on a clock edge with
//   start high and busy low. in_command 0 adds a building [left, right) of
//   in_building_height; in_command 1 fetches the next outline point.
//   Result channel: out_valid strobes for one cycle per fetch with
//   out_point_x, out_point_height and out_last_point; there is no stall.
//   Queue: commands pass a two-entry queue to the executor. An add walks
//   the store columns [left, right), one store column a cycle. A fetch
//   examines columns onward from the scan position until the height
//   changes or max right is reached; the last point is followed by a sweep
//   that clears store columns 0 to max_right - 1. busy rises while the
//   queue is full.
//   Reset: a clearing sweep of all X_SPAN columns runs first; busy stays high
//   until it ends.
// ----------------------------------------------------------------------------
module skyline_outline_builder_unit #(
  parameter int X_SPAN      = sob_pkg::X_SPAN_DEF,
  parameter int HEIGHT_BITS = sob_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_command,
  input  logic [sob_pkg::LEFT_W-1:0]      in_left_edge,
  input  logic [sob_pkg::COORD_W-1:0]     in_right_edge,
  input  logic [sob_pkg::IN_HEIGHT_W-1:0] in_building_height,
  output logic                            out_valid,
  output logic [sob_pkg::COORD_W-1:0]     out_point_x,
  output logic [sob_pkg::IN_HEIGHT_W-1:0] out_point_height,
  output logic                            out_last_point
);

  sob_pkg::item_t      push_item;
  sob_pkg::item_t      head_item;
  sob_pkg::back_stat_t stat;
  logic                push;
  logic                q_full;
  logic                q_empty;

  sob_front #(
    .X_SPAN (X_SPAN)
  ) u_front (
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_left_edge       (in_left_edge),
    .in_right_edge      (in_right_edge),
    .in_building_height (in_building_height),
    .q_full             (q_full),
    .stat               (stat),
    .push               (push),
    .item               (push_item)
  );

  sob_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (stat.pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  sob_back #(
    .X_SPAN      (X_SPAN),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (head_item),
    .q_empty          (q_empty),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_point_x      (out_point_x),
    .out_point_height (out_point_height),
    .out_last_point   (out_last_point)
  );

endmodule
